// File: design/mtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// shared types and constants of the move-to-front codec
// ----------------------------------------------------------------------------
package mtf_pkg;

    localparam int DATA_W = 8;

    // all ones position, reported for a symbol outside the alphabet
    localparam logic [DATA_W-1:0] NOT_FOUND_POS = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } mtf_state_t;

    // controls sent from the sequencer to the ring of cells
    typedef struct packed {
        logic              shift;
        logic              load_id;
        logic              head_load;
        logic [DATA_W-1:0] head_val;
        logic [DATA_W-1:0] tail_val;
    } mtf_ring_ctl_t;

endpackage

// File: design/mtf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_cell
// one list entry; shifts toward the head and reloads its own index
// ----------------------------------------------------------------------------
module mtf_cell
    import mtf_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  mtf_ring_ctl_t     ring,
    input  logic [DATA_W-1:0] shift_in,
    output logic [DATA_W-1:0] value
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ring.load_id)
        begin
            value_next = DATA_W'(INDEX);
        end
        else if (ring.shift)
        begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= DATA_W'(INDEX);
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// File: design/mtf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ctrl
// request sequencer: rotates the list once per request and keeps the result
// ----------------------------------------------------------------------------
module mtf_ctrl
    import mtf_pkg::*;
#(
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              decode_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] data_in,
    input  logic              block_last,
    input  logic [DATA_W-1:0] head,
    output mtf_ring_ctl_t     ring,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] data_out,
    output logic              out_last
);

    localparam int CNT_W = $clog2(ALPHABET_SIZE);
    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(ALPHABET_SIZE - 1);
    localparam logic [DATA_W:0] SIZE_EXT = (DATA_W + 1)'(ALPHABET_SIZE);

    mtf_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] din_reg, din_next;
    logic              last_reg, last_next;
    logic              plain_reg, plain_next;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] hold_reg, hold_next;
    logic [DATA_W-1:0] sym_reg, sym_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              last_step;
    logic              match;
    logic [DATA_W-1:0] match_res;
    logic [DATA_W-1:0] final_res;
    logic              slot_free;
    logic              in_over;

    assign last_step = (cnt_reg == LAST_POS);
    assign slot_free = !out_valid_reg || out_ready;
    assign in_over   = ({1'b0, data_in} >= SIZE_EXT);
    assign match_res = decode_mode ? head : DATA_W'(cnt_reg);

    always_comb
    begin
        match = 1'b0;
        if (state_reg == ST_SCAN && !plain_reg && !found_reg)
        begin
            match = decode_mode ? (cnt_reg == pos_reg) : (head == din_reg);
        end
    end

    always_comb
    begin
        if (plain_reg)
        begin
            final_res = NOT_FOUND_POS;
        end
        else if (match)
        begin
            final_res = match_res;
        end
        else
        begin
            final_res = res_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        din_next       = din_reg;
        last_next      = last_reg;
        plain_next     = plain_reg;
        found_next     = found_reg;
        hold_next      = hold_reg;
        sym_next       = sym_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;

        ring.shift     = 1'b0;
        ring.load_id   = 1'b0;
        ring.head_load = 1'b0;
        ring.head_val  = found_reg ? sym_reg : head;
        ring.tail_val  = (plain_reg || found_reg) ? head : hold_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    din_next   = data_in;
                    last_next  = block_last;
                    plain_next = !decode_mode && in_over;
                    pos_next   = in_over ? LAST_POS : data_in[CNT_W-1:0];
                    found_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                ring.shift = 1'b1;
                if (!found_reg)
                begin
                    hold_next = head;
                end
                if (match)
                begin
                    found_next = 1'b1;
                    sym_next   = head;
                    res_next   = match_res;
                end
                cnt_next = cnt_reg + 1'b1;
                if (last_step)
                begin
                    // close the gap left at the head with the moved symbol
                    ring.head_load = !plain_reg;
                    ring.load_id   = last_reg;
                    res_next       = final_res;
                    cnt_next       = '0;
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = final_res;
                        out_last_next  = last_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end

            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            plain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            plain_reg     <= plain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        din_reg      <= din_next;
        last_reg     <= last_next;
        hold_reg     <= hold_next;
        sym_reg      <= sym_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign out_last  = out_last_reg;

    // a new request always starts the scan at the head
    a_scan_starts_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (cnt_reg == '0 && state_reg == ST_SCAN))
        else $error("scan did not start at the head");

    // an out-of-alphabet symbol never matches an entry
    a_plain_never_found: assert property (@(posedge clk) disable iff (!rst_n)
        !(plain_reg && found_reg))
        else $error("match recorded for an out-of-alphabet symbol");

    // every in-alphabet request finds its entry by the end of the scan
    a_match_by_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && last_step && !plain_reg) |-> (found_reg || match))
        else $error("scan ended without a match");

    // finishing a scan never drops a result still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && last_step && out_valid_reg && !out_ready)
            |=> (state_reg == ST_HOLD))
        else $error("result overwrote a pending output");

endmodule

// File: design/move_to_front_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_codec_top
// byte move-to-front encoder / decoder built from a ring of list cells
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid / in_ready carries data_in and block_last, one
//   request per byte; output channel out_valid / out_ready returns data_out
//   and out_last, exactly one result per request, in order
//   cfg_valid / cfg_ready / cfg_data writes decode_mode (0 encode, 1 decode);
//   cfg_ready is always high, write only while no request is in flight
// timing
//   each request rotates the whole list once through the cell ring, one cell
//   per cycle; the sequencer takes a new request only in idle, after the
//   result of the last one has gone to the output register, and the result
//   is registered when the scan ends
// reset
//   every cell returns to identity order and decode_mode clears to encode;
//   block_last also restores identity order at the end of that request
// stall
//   the result sits in an output register; if it is not taken when the next
//   scan ends, that result waits in the sequencer and no request is taken
// ----------------------------------------------------------------------------
module move_to_front_codec_top
    import mtf_pkg::*;
#(
    parameter int ALPHABET_SIZE = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    // request side
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] data_in,
    input  logic              block_last,
    // result side
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] data_out,
    output logic              out_last
);

    logic              decode_mode_reg;
    logic              decode_mode_next;
    mtf_ring_ctl_t     ring;
    logic [DATA_W-1:0] cell_val   [ALPHABET_SIZE];
    logic [DATA_W-1:0] cell_shift [ALPHABET_SIZE];

    // config register, always ready
    assign cfg_ready        = 1'b1;
    assign decode_mode_next = cfg_valid ? cfg_data : decode_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
        end
        else
        begin
            decode_mode_reg <= decode_mode_next;
        end
    end

    // sequencer: sees only the head cell, feeds the tail cell and, at scan end, the head cell
    mtf_ctrl #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .decode_mode (decode_mode_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_in     (data_in),
        .block_last  (block_last),
        .head        (cell_val[0]),
        .ring        (ring),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .out_last    (out_last)
    );

    // ring of cells: each cycle of a scan every entry steps one place toward
    // the head; each non-matching head entry is examined and returns to the tail
    for (genvar i = 0; i < ALPHABET_SIZE; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign cell_shift[i] = ring.head_load ? ring.head_val : cell_val[i+1];
        end
        else if (i == ALPHABET_SIZE - 1)
        begin : g_tail
            assign cell_shift[i] = ring.tail_val;
        end
        else
        begin : g_mid
            assign cell_shift[i] = cell_val[i+1];
        end

        mtf_cell #(
            .INDEX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ring     (ring),
            .shift_in (cell_shift[i]),
            .value    (cell_val[i])
        );
    end

endmodule
